@@ design/rbma_pkg.sv @@
// ----------------------------------------------------------------------------
// rbma_pkg
// Shared constants, widths and handoff types for the rectified block moving
// average.
// ----------------------------------------------------------------------------
package rbma_pkg;

	localparam int BLOCK_LEN  = 1000;
	localparam int WINDOW_LEN = 20;

	localparam int VAL_W = 14;
	localparam int ACC_W = 24;
	localparam int SUM_W = 19;

	localparam logic [VAL_W-1:0] OFFSET_RESET = VAL_W'(7415);

	localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	// Division by the block length: ceiling reciprocal, exact for any ACC_W-bit
	// dividend because the shift covers the dividend width plus log2 of the divisor.
	localparam int MEAN_SHIFT   = ACC_W + $clog2(BLOCK_LEN);
	localparam int MEAN_RECIP_W = ACC_W + 1;
	localparam int MEAN_PROD_W  = ACC_W + MEAN_RECIP_W;
	localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(
		((64'd1 << MEAN_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

	// Division by the window length, same scheme over the window sum.
	localparam int WIN_SHIFT   = SUM_W + $clog2(WINDOW_LEN);
	localparam int WIN_RECIP_W = SUM_W + 1;
	localparam int WIN_PROD_W  = SUM_W + WIN_RECIP_W;
	localparam logic [WIN_RECIP_W-1:0] WIN_RECIP = WIN_RECIP_W'(
		((64'd1 << WIN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	localparam int SUM_MAX = WINDOW_LEN * ((1 << VAL_W) - 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	// Completed block total handed from the front end to the queue.
	typedef struct packed {
		logic             push;
		logic [ACC_W-1:0] acc;
	} rbma_push_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] acc;
	} rbma_head_t;

endpackage

@@ design/rectified_block_moving_average_top.sv @@
// A block total passes the queue, then registers s1, s2, s3 and the output register.
// One sample per cycle; the back end takes one block total per cycle unless output stalls.
// The input stalls only when the four-entry queue of block totals is full.
// Reset clears the accumulator, sample count, ring of means and window sum at once,
// and loads the zero offset with its default; there is no clearing pass.
// ----------------------------------------------------------------------------
// rectified_block_moving_average_top
// Rectified block mean of ADC current samples with a moving-average estimate.
// ----------------------------------------------------------------------------
module rectified_block_moving_average_top
	import rbma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [VAL_W-1:0]       cfg_data,      // zero_offset
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [13:0] sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [13:0] block_mean, [27:14] window_estimate
);

	rbma_push_t q_push;
	rbma_head_t head;
	logic       q_full;
	logic       pop;

	rbma_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push)
	);

	rbma_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.pop    (pop),
		.head   (head)
	);

	rbma_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ design/rbma_front.sv @@
// ----------------------------------------------------------------------------
// rbma_front
// Takes samples, removes the zero offset, rectifies and accumulates them, and
// pushes the block total into the queue when a block completes.
// ----------------------------------------------------------------------------
module rbma_front
	import rbma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [VAL_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   q_full,
	output rbma_push_t             q_push
);

	logic [VAL_W-1:0] offset_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] sample;
	logic [VAL_W-1:0] mag;
	logic [ACC_W-1:0] acc_sum;
	logic             last;
	logic             accept;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = ~q_full;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign sample        = s_axis_tdata[VAL_W-1:0];

	always_comb begin
		if (sample >= offset_q) begin
			mag = sample - offset_q;
		end else begin
			mag = offset_q - sample;
		end
		acc_sum = acc_q + ACC_W'(mag);
		last    = (cnt_q == CNT_W'(BLOCK_LEN - 1));
	end

	assign q_push.push = accept & last;
	assign q_push.acc  = acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_sum;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < BLOCK_LEN)
		else $error("sample count left the block range");

endmodule

@@ design/rbma_queue.sv @@
// ----------------------------------------------------------------------------
// rbma_queue
// Short queue of block totals between the front end and the back end.
// ----------------------------------------------------------------------------
module rbma_queue
	import rbma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  rbma_push_t q_push,
	output logic       q_full,
	input  logic       pop,
	output rbma_head_t head
);

	logic [ACC_W-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign q_full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.acc   = mem_q[rd_ptr_q];
	assign do_pop     = pop & head.valid;

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem_q[wr_ptr_q] <= q_push.acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (q_push.push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!q_push.push && do_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.push |-> !q_full)
		else $error("block total pushed into a full queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= QUEUE_DEPTH)
		else $error("queue fill count beyond depth");

endmodule

@@ design/rbma_back.sv @@
// ----------------------------------------------------------------------------
// rbma_back
// Turns block totals into block means, updates the ring of recent means and
// its running sum, and forms the window estimate for the output word.
// ----------------------------------------------------------------------------
module rbma_back
	import rbma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  rbma_head_t             head,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic                   en;
	logic                   v_s1;
	logic [MEAN_PROD_W-1:0] prod_s1;
	logic                   v_s2;
	logic [VAL_W-1:0]       mean_s2;
	logic [SUM_W-1:0]       sum_s2;
	logic                   v_s3;
	logic [VAL_W-1:0]       mean_s3;
	logic [WIN_PROD_W-1:0]  prod_s3;
	logic                   out_valid_q;
	logic [VAL_W-1:0]       out_mean_q;
	logic [VAL_W-1:0]       out_est_q;

	logic [VAL_W-1:0]       ring_q [WINDOW_LEN];
	logic [PTR_W-1:0]       ptr_q;
	logic [SUM_W-1:0]       sum_q;

	logic [VAL_W-1:0]       mean;
	logic [VAL_W-1:0]       old_mean;
	logic [SUM_W-1:0]       sum_next;
	logic [PTR_W-1:0]       ptr_next;

	// The whole back end moves together whenever the output register can take a word.
	assign en  = ~out_valid_q | m_axis_tready;
	assign pop = en & head.valid;

	always_comb begin
		mean     = prod_s1[MEAN_SHIFT +: VAL_W];
		old_mean = ring_q[ptr_q];
		sum_next = sum_q + SUM_W'(mean) - SUM_W'(old_mean);
		if (ptr_q == PTR_W'(WINDOW_LEN - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = ptr_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= MEAN_PROD_W'(head.acc) * MEAN_PROD_W'(MEAN_RECIP);
			mean_s2  <= mean;
			sum_s2   <= sum_next;
			mean_s3  <= mean_s2;
			prod_s3  <= WIN_PROD_W'(sum_s2) * WIN_PROD_W'(WIN_RECIP);
			out_mean_q <= mean_s3;
			out_est_q  <= prod_s3[WIN_SHIFT +: VAL_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= head.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// The ring starts out all zero so that the estimate ramps up over the first window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				ring_q[i] <= '0;
			end
			ptr_q <= '0;
			sum_q <= '0;
		end else if (en && v_s1) begin
			ring_q[ptr_q] <= mean;
			ptr_q         <= ptr_next;
			sum_q         <= sum_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - 2 * VAL_W)'(0), out_est_q, out_mean_q};

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) < WINDOW_LEN)
		else $error("ring pointer left the window");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sum_q) <= SUM_MAX)
		else $error("window sum exceeds the largest possible ring total");

endmodule
